// ----- design/field_deinterlacer_line_average_core_macros.svh -----
// Assertion macros used by the checker file of the deinterlacer core
`ifndef FIELD_DEINTERLACER_LINE_AVERAGE_CORE_MACROS_SVH
`define FIELD_DEINTERLACER_LINE_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define FDLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdla assertion failed");

// Next-cycle implication, disabled while reset is held
`define FDLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdla assertion failed");

`endif

// ----- design/fdla_pkg.sv -----
// Shared constants, types and register codes of the deinterlacer core
package fdla_pkg;

    localparam int MAX_LINE_BYTES = 8192;
    localparam int MAX_LINES      = 4096;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = $clog2(MAX_LINE_BYTES);
    localparam int ROW_W   = $clog2(MAX_LINES);
    localparam int LEN_W   = COL_W + 1;
    localparam int LINES_W = ROW_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1920);
    localparam logic [LINES_W-1:0] LINES_RESET = LINES_W'(480);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_BYTES  = 2'd0,
        CFG_FRAME_LINES = 2'd1,
        CFG_KEEP_EVEN   = 2'd2,
        CFG_FULL_HEIGHT = 2'd3
    } t_cfg_idx;

    // One classified word handed from front to back: one or two results
    typedef struct packed {
        logic [ROW_W-1:0]  line;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              two;
    } t_job;

endpackage

// ----- design/fdla_in_if.sv -----
// Input byte channel of the deinterlacer core
interface fdla_in_if;
    logic                       valid;
    logic                       ready;
    logic [fdla_pkg::BYTE_W-1:0] sample_byte;

    modport source (output valid, output sample_byte, input ready);
    modport sink   (input valid, input sample_byte, output ready);
endinterface

// ----- design/fdla_out_if.sv -----
// Result channel of the deinterlacer core
interface fdla_out_if;
    logic                        valid;
    logic                        ready;
    logic [fdla_pkg::ROW_W-1:0]  out_line;
    logic [fdla_pkg::COL_W-1:0]  out_column;
    logic [fdla_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_run;

    modport source (output valid, output out_line, output out_column, output out_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_line, input out_column, input out_byte,
                    input last_of_run, output ready);
endinterface

// ----- design/fdla_cfg_if.sv -----
// Configuration write channel of the deinterlacer core
interface fdla_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fdla_pkg::CFG_IDX_W-1:0]  index;
    logic [fdla_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/fdla_front.sv -----
// Front end: registers, frame position counters, line store and word classification
module fdla_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fdla_in_if.sink            s_in,
    fdla_cfg_if.sink           s_cfg,
    output fdla_pkg::t_job     o_job,
    output logic               o_job_valid,
    input  logic               i_job_ready
);

    logic [fdla_pkg::LEN_W-1:0]   r_len;
    logic [fdla_pkg::LINES_W-1:0] r_lines;
    logic                         r_keep_even;
    logic                         r_full_height;
    logic [fdla_pkg::COL_W-1:0]   r_col;
    logic [fdla_pkg::ROW_W-1:0]   r_row;

    logic [fdla_pkg::BYTE_W-1:0]  r_store [fdla_pkg::MAX_LINE_BYTES];
    logic [fdla_pkg::BYTE_W-1:0]  r_rd;

    logic                         r_s1_valid;
    logic                         r_s1_emit;
    logic                         r_s1_two;
    logic                         r_s1_use_avg;
    logic                         r_s1_use_store;
    logic [fdla_pkg::ROW_W-1:0]   r_s1_line;
    logic [fdla_pkg::COL_W-1:0]   r_s1_col;
    logic [fdla_pkg::BYTE_W-1:0]  r_s1_byte;

    logic                         in_acc;
    logic                         cfg_acc;
    logic                         s1_done;
    logic                         last_col;
    logic                         last_row;
    logic                         kept;
    logic                         n_emit;
    logic                         n_two;
    logic                         n_use_avg;
    logic                         n_use_store;
    logic [fdla_pkg::ROW_W-1:0]   n_line;
    logic [fdla_pkg::LEN_W-1:0]   n_len;
    logic [fdla_pkg::LINES_W-1:0] n_lines;
    logic [fdla_pkg::LINES_W-1:0] cfg_lines;
    logic [fdla_pkg::BYTE_W:0]    pair_sum;

    assign cfg_acc     = s_cfg.valid && s_cfg.ready;
    assign in_acc      = s_in.valid && s_in.ready;
    assign s_cfg.ready = 1'b1;

    // Advance the front stage when its word is taken or yields nothing
    assign s1_done    = r_s1_valid && (!r_s1_emit || i_job_ready);
    assign s_in.ready = !r_s1_valid || s1_done;

    // Clamp frame size on the way into the registers
    assign cfg_lines = s_cfg.data[fdla_pkg::LINES_W-1:0];
    always_comb begin
        if (s_cfg.data == '0) begin
            n_len = fdla_pkg::LEN_W'(1);
        end else if (s_cfg.data > fdla_pkg::LEN_W'(fdla_pkg::MAX_LINE_BYTES)) begin
            n_len = fdla_pkg::LEN_W'(fdla_pkg::MAX_LINE_BYTES);
        end else begin
            n_len = s_cfg.data;
        end
        if (cfg_lines < fdla_pkg::LINES_W'(2)) begin
            n_lines = fdla_pkg::LINES_W'(2);
        end else if (cfg_lines > fdla_pkg::LINES_W'(fdla_pkg::MAX_LINES)) begin
            n_lines = fdla_pkg::LINES_W'(fdla_pkg::MAX_LINES);
        end else begin
            n_lines = cfg_lines;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= fdla_pkg::LEN_RESET;
            r_lines       <= fdla_pkg::LINES_RESET;
            r_keep_even   <= 1'b0;
            r_full_height <= 1'b0;
        end else if (cfg_acc) begin
            unique case (fdla_pkg::t_cfg_idx'(s_cfg.index))
                fdla_pkg::CFG_LINE_BYTES:  r_len         <= n_len;
                fdla_pkg::CFG_FRAME_LINES: r_lines       <= n_lines;
                fdla_pkg::CFG_KEEP_EVEN:   r_keep_even   <= s_cfg.data[0];
                fdla_pkg::CFG_FULL_HEIGHT: r_full_height <= s_cfg.data[0];
            endcase
        end
    end

    // Frame position: restart on any register write, wrap at line and frame end
    assign last_col = (r_col == fdla_pkg::COL_W'(r_len - fdla_pkg::LEN_W'(1)));
    assign last_row = (r_row == fdla_pkg::ROW_W'(r_lines - fdla_pkg::LINES_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_acc) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + fdla_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + fdla_pkg::COL_W'(1);
            end
        end
    end

    // Classify the incoming word by row parity and mode
    assign kept = (r_row[0] == 1'b0) == r_keep_even;

    always_comb begin
        n_emit      = 1'b0;
        n_two       = 1'b0;
        n_use_avg   = 1'b0;
        n_use_store = 1'b0;
        n_line      = r_row;
        if (r_full_height) begin
            if (kept) begin
                n_emit    = 1'b1;
                n_two     = (r_row != '0);
                n_use_avg = (r_row >= fdla_pkg::ROW_W'(2));
                n_line    = (r_row == '0) ? '0 : r_row - fdla_pkg::ROW_W'(1);
            end else if (last_row) begin
                n_emit      = 1'b1;
                n_use_store = 1'b1;
            end
        end else begin
            n_emit = kept && ({1'b0, r_row[fdla_pkg::ROW_W-1:1]}
                              < r_lines[fdla_pkg::LINES_W-1:1]);
            n_line = {1'b0, r_row[fdla_pkg::ROW_W-1:1]};
        end
    end

    // Line store: read old byte, write the kept byte in full-height mode at the same column
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_store[r_col];
            if (r_full_height && kept) begin
                r_store[r_col] <= s_in.sample_byte;
            end
        end
    end

    // Front stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Front stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_emit      <= n_emit;
            r_s1_two       <= n_two;
            r_s1_use_avg   <= n_use_avg;
            r_s1_use_store <= n_use_store;
            r_s1_line      <= n_line;
            r_s1_col       <= r_col;
            r_s1_byte      <= s_in.sample_byte;
        end
    end

    // Build the word for the queue
    assign pair_sum = {1'b0, r_rd} + {1'b0, r_s1_byte};

    always_comb begin
        o_job.line        = r_s1_line;
        o_job.col         = r_s1_col;
        o_job.second_byte = r_s1_byte;
        o_job.two         = r_s1_two;
        priority if (r_s1_use_store) begin
            o_job.first_byte = r_rd;
        end else if (r_s1_use_avg) begin
            o_job.first_byte = pair_sum[fdla_pkg::BYTE_W:1];
        end else begin
            o_job.first_byte = r_s1_byte;
        end
    end

    assign o_job_valid = r_s1_valid && r_s1_emit;

endmodule

// ----- design/fdla_queue.sv -----
// Short queue of classified words between front and back
module fdla_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdla_pkg::t_job     i_job,
    input  logic               i_valid,
    output logic               o_ready,
    output fdla_pkg::t_job     o_job,
    output logic               o_valid,
    input  logic               i_ready
);

    fdla_pkg::t_job              r_slot [fdla_pkg::QUEUE_DEPTH];
    logic [fdla_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [fdla_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [fdla_pkg::QCNT_W-1:0] r_count;
    logic                        push;
    logic                        pop;

    assign o_ready = (r_count != fdla_pkg::QCNT_W'(fdla_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_slot[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + fdla_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + fdla_pkg::QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + fdla_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - fdla_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold the pushed word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- design/fdla_back.sv -----
// Back end: output register that plays out one or two results per word
module fdla_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdla_pkg::t_job     i_job,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    fdla_out_if.source         m_out
);

    fdla_pkg::t_job r_job;
    logic           r_valid;
    logic           r_phase;
    logic           out_acc;
    logic           run_done;

    assign out_acc     = m_out.valid && m_out.ready;
    assign run_done    = !r_job.two || r_phase;
    assign o_job_ready = !r_valid || (out_acc && run_done);

    // Load a new word once the current run is out, else step to its second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_job_ready) begin
            r_valid <= i_job_valid;
            r_phase <= 1'b0;
        end else if (out_acc) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready) begin
            r_job <= i_job;
        end
    end

    // Drive the result word
    assign m_out.valid       = r_valid;
    assign m_out.out_line    = r_phase ? r_job.line + fdla_pkg::ROW_W'(1) : r_job.line;
    assign m_out.out_column  = r_job.col;
    assign m_out.out_byte    = r_phase ? r_job.second_byte : r_job.first_byte;
    assign m_out.last_of_run = run_done;

endmodule

// ----- design/field_deinterlacer_line_average_core.sv -----
// The first result of a byte passes the front stage, the queue and the output register
// in that order before it is offered.
// Throughput: one byte per cycle while the output is not stalled and the byte yields at most
// one result; in full-height mode kept rows past row 0 yield two, sharing the single output register.
// The 4-word queue between front and back absorbs short output stalls.
// Reset: registers return to 1920 bytes x 480 lines, odd field, packed; position and
// pipeline clear at once. The line store is not cleared and needs no clearing pass.
module field_deinterlacer_line_average_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdla_in_if.sink     i_in,
    fdla_cfg_if.sink    i_cfg,
    fdla_out_if.source  o_out
);

    fdla_pkg::t_job front_job;
    logic           front_valid;
    logic           front_ready;
    fdla_pkg::t_job back_job;
    logic           back_valid;
    logic           back_ready;

    fdla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (i_in),
        .s_cfg       (i_cfg),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    fdla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_job   (back_job),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    fdla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .m_out       (o_out)
    );

endmodule

// ----- design/fdla_checker.sv -----
// Port-level checks of the deinterlacer core and their binding
`include "field_deinterlacer_line_average_core_macros.svh"

module fdla_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [fdla_pkg::ROW_W-1:0]  i_out_line,
    input  logic [fdla_pkg::COL_W-1:0]  i_out_column,
    input  logic [fdla_pkg::BYTE_W-1:0] i_out_byte,
    input  logic                        i_out_last
);

    // Stalled result word stays offered
    `FDLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Stalled result payload stays put
    `FDLA_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_line) && $stable(i_out_column) && $stable(i_out_byte) && $stable(i_out_last))

    // First of a pair is followed at once by the next line, same column, closing the run
    `FDLA_ASSERT_NXT(a_pair_next, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid && i_out_last && (i_out_column == $past(i_out_column)) && (i_out_line == $past(i_out_line) + fdla_pkg::ROW_W'(1)))

    // Register writes are never stalled
    `FDLA_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready)

endmodule

bind field_deinterlacer_line_average_core fdla_checker u_fdla_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_line   (o_out.out_line),
    .i_out_column (o_out.out_column),
    .i_out_byte   (o_out.out_byte),
    .i_out_last   (o_out.last_of_run)
);
